// ----- rtl/bpdc_pkg.sv -----
// package: shared types, constants and event codes of the button press duration classifier
package bpdc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int PERIOD_W       = 16;
    localparam int ENABLE_W       = 6;
    localparam int DUR_W          = 32;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CODE_W         = 3;

    localparam logic [PERIOD_W-1:0] SHORT_RST  = 16'd50;
    localparam logic [PERIOD_W-1:0] MEDIUM_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] LONG_RST   = 16'd3000;
    localparam logic [ENABLE_W-1:0] ENABLE_RST = 6'd0;

    // enable bit positions
    localparam int EN_HELD_SHORT  = 0;
    localparam int EN_HELD_MEDIUM = 1;
    localparam int EN_HELD_LONG   = 2;
    localparam int EN_REL_SHORT   = 3;
    localparam int EN_REL_MEDIUM  = 4;
    localparam int EN_REL_LONG    = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT  = 2'd0,
        CFG_MEDIUM = 2'd1,
        CFG_LONG   = 2'd2,
        CFG_ENABLE = 2'd3
    } t_cfg_idx;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE        = 3'd0,
        EV_HELD_SHORT  = 3'd1,
        EV_HELD_MEDIUM = 3'd2,
        EV_HELD_LONG   = 3'd3,
        EV_REL_SHORT   = 3'd4,
        EV_REL_MEDIUM  = 3'd5,
        EV_REL_LONG    = 3'd6
    } t_event;

    typedef struct packed {
        logic [PERIOD_W-1:0] short_ms;
        logic [PERIOD_W-1:0] medium_ms;
        logic [PERIOD_W-1:0] long_ms;
        logic [ENABLE_W-1:0] event_enable;
    } t_cfg;

    typedef struct packed {
        logic armed;
        logic new_time;
    } t_status;

endpackage

// ----- rtl/button_press_duration_classifier.sv -----
// top level: input register, classifier, result register and config port
// an accepted item moves from the input register through the classifier into the result register
// throughput: one item per cycle while results are taken, set by the single classify stage between the registers
// the result register stalls when the result is not taken; the input register then stalls only if it holds an item
// reset: synchronous active low; clears state, config to defaults, both stages empty
module button_press_duration_classifier #(
    parameter int TIME_WIDTH = bpdc_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [TIME_WIDTH-1:0]           i_time_ms,
    input  logic                            i_button_level,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bpdc_pkg::CODE_W-1:0]     o_event_code,
    output logic [bpdc_pkg::DUR_W-1:0]      o_press_duration,
    input  logic                            i_cfg_we,
    input  logic [bpdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic                  r_in_valid;
    logic [TIME_WIDTH-1:0] r_in_time;
    logic                  r_in_level;

    logic                           r_out_valid;
    bpdc_pkg::t_event               r_out_code;
    logic [bpdc_pkg::DUR_W-1:0]     r_out_dur;

    logic                           w_adv;
    logic                           w_step;
    bpdc_pkg::t_cfg                 w_cfg;
    bpdc_pkg::t_event               w_code;
    logic [bpdc_pkg::DUR_W-1:0]     w_dur;
    bpdc_pkg::t_status              w_status;

    assign w_adv   = !r_out_valid || i_ready;
    assign w_step  = r_in_valid && w_adv;
    assign o_ready = !r_in_valid || w_adv;

    bpdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    bpdc_classify #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classify (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_time_ms        (r_in_time),
        .i_button_level   (r_in_level),
        .i_cfg            (w_cfg),
        .o_event_code     (w_code),
        .o_press_duration (w_dur),
        .o_status         (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_time  <= i_time_ms;
            r_in_level <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_code <= w_code;
            r_out_dur  <= w_dur;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_code     = r_out_code;
    assign o_press_duration = r_out_dur;

    // no event means no duration
    a_none_no_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_code == bpdc_pkg::EV_NONE) |-> (o_press_duration == '0))
        else $error("duration reported without event");

    // held events carry no duration
    a_held_no_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_code == bpdc_pkg::EV_HELD_SHORT
                     || o_event_code == bpdc_pkg::EV_HELD_MEDIUM
                     || o_event_code == bpdc_pkg::EV_HELD_LONG))
        |-> (o_press_duration == '0))
        else $error("held event with nonzero duration");

    // any event needs an armed press
    a_event_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_code != bpdc_pkg::EV_NONE) |-> (w_status.armed && w_status.new_time))
        else $error("event while not armed");

    // a release on a new time always disarms
    a_release_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_status.armed && w_status.new_time && r_in_level) |=> !w_status.armed)
        else $error("release did not disarm");

endmodule

// ----- rtl/bpdc_cfg_regs.sv -----
// configuration register file: band periods and event enable mask
module bpdc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpdc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output bpdc_pkg::t_cfg                    o_cfg
);

    bpdc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ms     <= bpdc_pkg::SHORT_RST;
            r_cfg.medium_ms    <= bpdc_pkg::MEDIUM_RST;
            r_cfg.long_ms      <= bpdc_pkg::LONG_RST;
            r_cfg.event_enable <= bpdc_pkg::ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (bpdc_pkg::t_cfg_idx'(i_cfg_index))
                bpdc_pkg::CFG_SHORT: begin
                    r_cfg.short_ms <= i_cfg_wdata[bpdc_pkg::PERIOD_W-1:0];
                end
                bpdc_pkg::CFG_MEDIUM: begin
                    r_cfg.medium_ms <= i_cfg_wdata[bpdc_pkg::PERIOD_W-1:0];
                end
                bpdc_pkg::CFG_LONG: begin
                    r_cfg.long_ms <= i_cfg_wdata[bpdc_pkg::PERIOD_W-1:0];
                end
                bpdc_pkg::CFG_ENABLE: begin
                    r_cfg.event_enable <= i_cfg_wdata[bpdc_pkg::ENABLE_W-1:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bpdc_classify.sv -----
// press tracking state and band classification of one item
module bpdc_classify #(
    parameter int TIME_WIDTH = bpdc_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [TIME_WIDTH-1:0]         i_time_ms,
    input  logic                          i_button_level,
    input  bpdc_pkg::t_cfg                i_cfg,
    output bpdc_pkg::t_event              o_event_code,
    output logic [bpdc_pkg::DUR_W-1:0]    o_press_duration,
    output bpdc_pkg::t_status             o_status
);

    logic                  r_armed;
    logic [TIME_WIDTH-1:0] r_start;
    logic [TIME_WIDTH-1:0] r_last;

    logic                  w_pressed;
    logic                  w_new;
    logic [TIME_WIDTH-1:0] w_es;
    logic [TIME_WIDTH-1:0] w_em;
    logic [TIME_WIDTH-1:0] w_el;
    logic [TIME_WIDTH-1:0] w_dt;
    logic [bpdc_pkg::ENABLE_W-1:0] w_en;

    assign w_pressed = !i_button_level;
    assign w_new     = (i_time_ms != r_last);
    assign w_en      = i_cfg.event_enable;
    assign w_es      = r_start + TIME_WIDTH'(i_cfg.short_ms);
    assign w_em      = r_start + TIME_WIDTH'(i_cfg.medium_ms);
    assign w_el      = r_start + TIME_WIDTH'(i_cfg.long_ms);
    assign w_dt      = i_time_ms - r_start;

    always_comb begin
        o_event_code     = bpdc_pkg::EV_NONE;
        o_press_duration = '0;
        if (w_new && r_armed) begin
            if (w_pressed) begin
                priority if (w_en[bpdc_pkg::EN_HELD_SHORT] && w_es == i_time_ms) begin
                    o_event_code = bpdc_pkg::EV_HELD_SHORT;
                end else if (w_en[bpdc_pkg::EN_HELD_MEDIUM] && w_em == i_time_ms) begin
                    o_event_code = bpdc_pkg::EV_HELD_MEDIUM;
                end else if (w_en[bpdc_pkg::EN_HELD_LONG] && w_el == i_time_ms) begin
                    o_event_code = bpdc_pkg::EV_HELD_LONG;
                end else begin
                    o_event_code = bpdc_pkg::EV_NONE;
                end
            end else begin
                priority if (w_en[bpdc_pkg::EN_REL_SHORT] && w_es <= i_time_ms
                             && w_em > i_time_ms) begin
                    o_event_code     = bpdc_pkg::EV_REL_SHORT;
                    o_press_duration = bpdc_pkg::DUR_W'(w_dt);
                end else if (w_en[bpdc_pkg::EN_REL_MEDIUM] && w_em <= i_time_ms
                             && w_el > i_time_ms) begin
                    o_event_code     = bpdc_pkg::EV_REL_MEDIUM;
                    o_press_duration = bpdc_pkg::DUR_W'(w_dt);
                end else if (w_en[bpdc_pkg::EN_REL_LONG] && w_el <= i_time_ms) begin
                    o_event_code     = bpdc_pkg::EV_REL_LONG;
                    o_press_duration = bpdc_pkg::DUR_W'(w_dt);
                end else begin
                    o_event_code = bpdc_pkg::EV_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_start <= '0;
            r_last  <= '0;
        end else if (i_step && w_new) begin
            r_last <= i_time_ms;
            if (r_armed) begin
                if (!w_pressed) begin
                    r_armed <= 1'b0;
                end
            end else if (w_pressed) begin
                r_armed <= 1'b1;
                r_start <= i_time_ms;
            end
        end
    end

    assign o_status.armed    = r_armed;
    assign o_status.new_time = w_new;

endmodule
